FILE: sv/fntt_pkg.sv
// Shared types, codes and constants of the forward NTT core.
`default_nettype none
package fntt_pkg;

   localparam int DEF_MAX_POINTS = 4096;

   // Request kinds.
   localparam logic [2:0] KIND_WR_COEF  = 3'd0;
   localparam logic [2:0] KIND_WR_TWID  = 3'd1;
   localparam logic [2:0] KIND_WR_HINT  = 3'd2;
   localparam logic [2:0] KIND_RUN      = 3'd3;
   localparam logic [2:0] KIND_RD_COEF  = 3'd4;

   // Register indexes.
   localparam logic [1:0] CSR_LOG_N    = 2'd0;
   localparam logic [1:0] CSR_MODULUS  = 2'd1;
   localparam logic [1:0] CSR_MODE     = 2'd2;
   localparam logic [1:0] CSR_QINV     = 2'd3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [11:0] slot;
      logic [63:0] word;
   } req_type;

   typedef struct packed {
      logic [61:0] coefficient;
      logic [11:0] position;
      logic        finished;
   } rsp_type;

endpackage
`default_nettype wire

FILE: sv/forward_ntt_modular_core.sv
// Top level of the in-place radix-2 forward NTT core with its coefficient and table memories.
`default_nettype none
// Channel   | Direction | Payload   | Handshake
// ----------+-----------+-----------+-----------------------------------------
// request   | in        | req_data  | req_valid / req_stall, taken when !stall
// response  | out       | rsp_data  | rsp_valid / rsp_stall, taken when !stall
// csr       | in        | csr_data  | csr_write_en with csr_index, no wait
//
// Coefficient, twiddle and hint writes are taken one per cycle while the core is
// idle and no read is pending, also while a response waits. A read request stalls
// the input while the registered memory data moves to the output register.
// A run request holds the input stalled for all (N/2)*log2(N) butterflies; each
// butterfly runs three sequential 64x64 products on the shared multiplier.
// Reset is synchronous and clears only control state; memory contents are
// undefined until written.
module forward_ntt_modular_core
   import fntt_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = AW + 1;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD_A = 4'd1;
   localparam logic [3:0] ST_RD_B = 4'd2;
   localparam logic [3:0] ST_LOAD = 4'd3;
   localparam logic [3:0] ST_M1S  = 4'd4;
   localparam logic [3:0] ST_M1W  = 4'd5;
   localparam logic [3:0] ST_M2S  = 4'd6;
   localparam logic [3:0] ST_M2W  = 4'd7;
   localparam logic [3:0] ST_M3S  = 4'd8;
   localparam logic [3:0] ST_M3W  = 4'd9;
   localparam logic [3:0] ST_CORR = 4'd10;
   localparam logic [3:0] ST_WR_D = 4'd11;
   localparam logic [3:0] ST_WR_S = 4'd12;
   localparam logic [3:0] ST_DONE = 4'd13;

   // Configuration registers.
   logic [3:0]  log_n_ff;
   logic [61:0] modulus_ff;
   logic        mode_ff;
   logic [63:0] qinv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_n_ff   <= 4'd12;
         modulus_ff <= 62'd3;
         mode_ff    <= 1'b0;
         qinv_ff    <= 64'd0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LOG_N:   log_n_ff   <= csr_data[3:0];
            CSR_MODULUS: modulus_ff <= csr_data[61:0];
            CSR_MODE:    mode_ff    <= csr_data[0];
            default:     qinv_ff    <= csr_data;
         endcase
      end
   end

   // Memories.
   logic [61:0] coef_mem [MAX_POINTS];
   logic [61:0] twid_mem [MAX_POINTS];
   logic [63:0] hint_mem [MAX_POINTS];
   logic [61:0] coef_q_ff, twid_q_ff;
   logic [63:0] hint_q_ff;

   logic          coef_we, twid_we, hint_we;
   logic [AW-1:0] coef_wa, coef_ra;
   logic [61:0]   coef_wd;

   // Control and datapath registers.
   logic [3:0]    state_ff, state_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [AW-1:0] rd_idx_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff;
   logic [NW-1:0] n_ff, t_ff, j_ff, widx_ff;
   logic [63:0]   a_ff, b_ff, w_ff, r_ff, v_ff, p2_ff;
   logic [127:0]  p1_ff;

   // Request decode. The slot wraps to the memory depth.
   logic          req_take;
   logic          req_needs_out;
   logic [31:0]   slot_wide;
   logic [AW-1:0] req_idx;
   logic [NW-1:0] n_sel;

   always_comb begin
      slot_wide     = {20'd0, req_data.slot};
      req_idx       = slot_wide[AW-1:0];
      req_needs_out = (req_data.kind == KIND_RUN) || (req_data.kind == KIND_RD_COEF);
      // A request that produces a response waits until the output slot frees.
      req_stall     = (state_ff != ST_IDLE) || rd_pend_ff ||
                      (req_needs_out && rsp_valid_ff && rsp_stall);
      req_take      = req_valid && !req_stall;
      if (32'(log_n_ff) >= AW) begin
         n_sel = NW'(1) << AW;
      end else begin
         n_sel = NW'(1) << log_n_ff;
      end
   end

   // Shared multiplier.
   logic         mul_start;
   logic [63:0]  mul_x, mul_y;
   logic         mul_done;
   logic [127:0] mul_p;

   fntt_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .done    (mul_done),
      .product (mul_p)
   );

   logic [63:0] q64;
   assign q64 = {2'd0, modulus_ff};

   // Barrett: b*r (high half), b*w (low), hi*q (low).
   // Montgomery: b*w (full), low*qinv (low), u*q (high).
   always_comb begin
      mul_start = 1'b0;
      mul_x     = b_ff;
      mul_y     = w_ff;
      unique case (state_ff)
         ST_M1S: begin
            mul_start = 1'b1;
            mul_y     = mode_ff ? w_ff : r_ff;
         end
         ST_M2S: begin
            mul_start = 1'b1;
            mul_x     = mode_ff ? p1_ff[63:0] : b_ff;
            mul_y     = mode_ff ? qinv_ff : w_ff;
         end
         ST_M3S: begin
            mul_start = 1'b1;
            mul_x     = mode_ff ? p2_ff : p1_ff[127:64];
            mul_y     = q64;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   // Butterfly add and subtract; sums wrap at 64 bits.
   logic [63:0] sum_raw, sum_red, diff_val;
   always_comb begin
      sum_raw  = a_ff + v_ff;
      sum_red  = (sum_raw >= q64) ? sum_raw - q64 : sum_raw;
      diff_val = (a_ff >= v_ff) ? a_ff - v_ff : a_ff + q64 - v_ff;
   end

   // Index walk: j runs through a group of t butterflies, then skips the
   // upper half; the twiddle index advances once per group across stages.
   logic          last_in_group;
   logic [NW-1:0] j_skip;
   logic [NW-1:0] j_plus_t;
   always_comb begin
      last_in_group = ((j_ff & (t_ff - NW'(1))) == (t_ff - NW'(1)));
      j_skip        = j_ff + NW'(1) + t_ff;
      j_plus_t      = j_ff + t_ff;
   end

   // Memory port control.
   always_comb begin
      coef_we = 1'b0;
      coef_wa = req_idx;
      coef_wd = req_data.word[61:0];
      coef_ra = req_idx;
      twid_we = req_take && (req_data.kind == KIND_WR_TWID);
      hint_we = req_take && (req_data.kind == KIND_WR_HINT);
      unique case (state_ff)
         ST_IDLE: coef_we = req_take && (req_data.kind == KIND_WR_COEF);
         ST_RD_A: coef_ra = j_ff[AW-1:0];
         ST_RD_B: coef_ra = j_plus_t[AW-1:0];
         ST_WR_D: begin
            coef_we = 1'b1;
            coef_wa = j_plus_t[AW-1:0];
            coef_wd = diff_val[61:0];
         end
         ST_WR_S: begin
            coef_we = 1'b1;
            coef_wa = j_ff[AW-1:0];
            coef_wd = sum_red[61:0];
         end
         default: coef_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_wa] <= coef_wd;
      end
      coef_q_ff <= coef_mem[coef_ra];
   end

   always_ff @(posedge clock) begin
      if (twid_we) begin
         twid_mem[req_idx] <= req_data.word[61:0];
      end
      twid_q_ff <= twid_mem[widx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (hint_we) begin
         hint_mem[req_idx] <= req_data.word;
      end
      hint_q_ff <= hint_mem[widx_ff[AW-1:0]];
   end

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      rd_pend_in = req_take && (req_data.kind == KIND_RD_COEF);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_data.kind == KIND_RUN)) begin
               state_in = (n_sel == NW'(1)) ? ST_DONE : ST_RD_A;
            end
         end
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: state_in = ST_LOAD;
         ST_LOAD: state_in = ST_M1S;
         ST_M1S:  state_in = ST_M1W;
         ST_M1W:  state_in = mul_done ? ST_M2S : ST_M1W;
         ST_M2S:  state_in = ST_M2W;
         ST_M2W:  state_in = mul_done ? ST_M3S : ST_M2W;
         ST_M3S:  state_in = ST_M3W;
         ST_M3W:  state_in = mul_done ? ST_CORR : ST_M3W;
         ST_CORR: state_in = ST_WR_D;
         ST_WR_D: state_in = ST_WR_S;
         ST_WR_S: begin
            if (last_in_group && (j_skip == n_ff) && (t_ff == NW'(1))) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RD_A;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rd_pend_ff || (state_ff == ST_DONE)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   logic [31:0] pos_wide;
   assign pos_wide = 32'(rd_idx_ff);

   always_ff @(posedge clock) begin
      if (req_take) begin
         rd_idx_ff <= req_idx;
      end
      if (rd_pend_ff) begin
         rsp_data_ff.coefficient <= coef_q_ff;
         rsp_data_ff.position    <= pos_wide[11:0];
         rsp_data_ff.finished    <= 1'b0;
      end else if (state_ff == ST_DONE) begin
         rsp_data_ff.coefficient <= 62'd0;
         rsp_data_ff.position    <= 12'd0;
         rsp_data_ff.finished    <= 1'b1;
      end
   end

   // Datapath registers of the running transform.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            n_ff    <= n_sel;
            t_ff    <= n_sel >> 1;
            j_ff    <= '0;
            widx_ff <= NW'(1);
         end
         ST_RD_B: a_ff <= {2'd0, coef_q_ff};
         ST_LOAD: begin
            b_ff <= {2'd0, coef_q_ff};
            w_ff <= {2'd0, twid_q_ff};
            r_ff <= hint_q_ff;
         end
         ST_M1W: begin
            if (mul_done) begin
               p1_ff <= mul_p;
            end
         end
         ST_M2W: begin
            if (mul_done) begin
               p2_ff <= mul_p[63:0];
            end
         end
         ST_M3W: begin
            if (mul_done) begin
               if (mode_ff) begin
                  // Montgomery: high(P) - high(u*q), add q back on borrow.
                  v_ff <= (p1_ff[127:64] < mul_p[127:64]) ?
                          p1_ff[127:64] - mul_p[127:64] + q64 :
                          p1_ff[127:64] - mul_p[127:64];
               end else begin
                  v_ff <= p2_ff - mul_p[63:0];
               end
            end
         end
         ST_CORR: begin
            // Barrett leaves one conditional subtract of q.
            if (!mode_ff && (v_ff >= q64)) begin
               v_ff <= v_ff - q64;
            end
         end
         ST_WR_S: begin
            if (!last_in_group) begin
               j_ff <= j_ff + NW'(1);
            end else begin
               widx_ff <= widx_ff + NW'(1);
               if (j_skip == n_ff) begin
                  j_ff <= '0;
                  t_ff <= t_ff >> 1;
               end else begin
                  j_ff <= j_skip;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: sv/fntt_mul.sv
// Multi-cycle 64x64 to 128-bit multiplier built from four 32x32 partial products.
`default_nettype none
module fntt_mul
   import fntt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [63:0]  x,
   input  wire logic [63:0]  y,
   output logic              done,
   output logic [127:0]      product
);

   logic [63:0]  x_ff, y_ff;
   logic [1:0]   step_ff;
   logic         run_ff, run_in;
   logic [63:0]  pp_ff;
   logic [1:0]   sh_ff;
   logic         last_ff;
   logic         addv_ff, addv_in;
   logic         done_ff, done_in;
   logic [127:0] acc_ff;
   logic [31:0]  xpart, ypart;
   logic [127:0] pp_shifted;

   // Partial product order: low*low, low*high, high*low, high*high.
   always_comb begin
      xpart = step_ff[1] ? x_ff[63:32] : x_ff[31:0];
      ypart = step_ff[0] ? y_ff[63:32] : y_ff[31:0];
   end

   always_comb begin
      unique case (sh_ff)
         2'd0:    pp_shifted = {64'd0, pp_ff};
         2'd1:    pp_shifted = {32'd0, pp_ff, 32'd0};
         default: pp_shifted = {pp_ff, 64'd0};
      endcase
   end

   always_comb begin
      run_in  = run_ff;
      addv_in = 1'b0;
      done_in = 1'b0;
      if (start) begin
         run_in = 1'b1;
      end else if (run_ff) begin
         addv_in = 1'b1;
         if (step_ff == 2'd3) begin
            run_in = 1'b0;
         end
      end
      if (!start && addv_ff && last_ff) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         addv_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         run_ff  <= run_in;
         addv_ff <= addv_in;
         done_ff <= done_in;
         if (start) begin
            step_ff <= 2'd0;
         end else if (run_ff) begin
            step_ff <= step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= x;
         y_ff   <= y;
         acc_ff <= 128'd0;
      end else begin
         if (run_ff) begin
            pp_ff   <= {32'd0, xpart} * {32'd0, ypart};
            sh_ff   <= 2'(step_ff[1] + step_ff[0]);
            last_ff <= (step_ff == 2'd3);
         end
         if (addv_ff) begin
            acc_ff <= acc_ff + pp_shifted;
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench of the forward NTT core: loads, runs and read-back.
`default_nettype none
module testbench;
   import fntt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POINTS     = DEF_MAX_POINTS;
   localparam int IDLE_LIMIT = 200000;
   localparam int SETTLE     = 12;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   forward_ntt_modular_core u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // Requests waiting to be driven, and responses the core still owes us.
   req_type pending_requests[$];
   rsp_type owed_responses[$];

   // Our own copy of the core's registers and memories.
   logic [3:0]  model_log_n;
   logic [61:0] model_modulus;
   logic        model_mode;
   logic [63:0] model_qinv;
   logic [61:0] coef_mem[POINTS];
   logic [61:0] twid_mem[POINTS];
   logic [63:0] hint_mem[POINTS];

   // Which entries the stimulus has written, so that nothing unwritten is read.
   bit coef_loaded[POINTS];
   bit twid_loaded[POINTS];
   bit hint_loaded[POINTS];

   int mismatches;
   int idle_cycles;
   bit req_taken;
   bit rsp_taken;
   int req_gap;
   int rsp_hold;
   bit req_burst;
   bit rsp_burst;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Twiddle product of one coefficient, in the mode currently selected.
   function automatic logic [63:0] twiddle_product(logic [63:0] t, logic [63:0] w,
                                                   logic [63:0] r);
      logic [127:0] p;
      logic [127:0] uq;
      logic [63:0]  u;
      logic [63:0]  q;
      logic [63:0]  v;
      q = {2'b00, model_modulus};
      if (model_mode) begin
         p  = {64'd0, t} * {64'd0, w};
         u  = p[63:0] * model_qinv;
         uq = {64'd0, u} * {64'd0, q};
         v  = p[127:64] - uq[127:64];
         if (p[127:64] < uq[127:64])
            v = v + q;
      end else begin
         p = {64'd0, t} * {64'd0, r};
         v = t * w - p[127:64] * q;
         if (v >= q)
            v = v - q;
      end
      return v;
   endfunction

   // All stages of the in-place transform over the first N coefficients.
   task automatic transform_in_place();
      int n;
      int half;
      int m;
      logic [63:0] a;
      logic [63:0] v;
      logic [63:0] s;
      logic [63:0] d;
      logic [63:0] q;
      q = {2'b00, model_modulus};
      n = (model_log_n > 12) ? POINTS : (1 << model_log_n);
      half = n;
      for (m = 1; m < n; m = m * 2) begin
         half = half / 2;
         for (int i = 0; i < m; i++) begin
            for (int j = 2 * half * i; j < 2 * half * i + half; j++) begin
               a = {2'b00, coef_mem[j]};
               v = twiddle_product({2'b00, coef_mem[j + half]},
                                   {2'b00, twid_mem[m + i]}, hint_mem[m + i]);
               s = a + v;
               if (s >= q)
                  s = s - q;
               if (a >= v)
                  d = a - v;
               else
                  d = a + q - v;
               coef_mem[j + half] = d[61:0];
               coef_mem[j] = s[61:0];
            end
         end
      end
   endtask

   // Applies one accepted request to the copy and queues its response, if any.
   task automatic apply_request(req_type r);
      rsp_type e;
      case (r.kind)
         KIND_WR_COEF: coef_mem[r.slot] = r.word[61:0];
         KIND_WR_TWID: twid_mem[r.slot] = r.word[61:0];
         KIND_WR_HINT: hint_mem[r.slot] = r.word;
         KIND_RUN: begin
            transform_in_place();
            e.coefficient = '0;
            e.position = '0;
            e.finished = 1'b1;
            owed_responses.push_back(e);
         end
         KIND_RD_COEF: begin
            e.coefficient = coef_mem[r.slot];
            e.position = r.slot;
            e.finished = 1'b0;
            owed_responses.push_back(e);
         end
         default: ;
      endcase
   endtask

   // Sampling at the rising edge: prediction, checking and the watchdog.
   always @(posedge clock) begin
      rsp_type e;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         req_taken = req_valid && !req_stall;
         rsp_taken = rsp_valid && !rsp_stall;
         if (req_taken)
            apply_request(req_data);
         if (rsp_taken) begin
            if (owed_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: coefficient %h position %0d finished %b",
                           rsp_data.coefficient, rsp_data.position, rsp_data.finished);
            end else begin
               e = owed_responses.pop_front();
               if (e !== rsp_data) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
                              e.coefficient, e.position, e.finished,
                              rsp_data.coefficient, rsp_data.position,
                              rsp_data.finished);
               end
            end
         end
         if (req_taken || rsp_taken)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("** forward_ntt_modular_core: FAILED **");
            $finish;
         end
      end
   end

   // Request driver: inputs change on the falling edge. A request just taken is
   // followed by a random gap, unless a burst stretch is in progress.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (req_valid && !req_taken) begin
         // Held while stalled.
      end else begin
         if (req_taken) begin
            if ($urandom_range(0, 31) == 0)
               req_burst = !req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 7);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            req_data <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall: each taken response draws how long the next one waits.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 31) == 0)
               rsp_burst = !rsp_burst;
            rsp_hold = rsp_burst ? 0 : $urandom_range(0, 7);
         end
         rsp_stall <= (rsp_hold != 0);
         if (rsp_hold != 0)
            rsp_hold--;
      end
   end

   // Waits until every request is taken and every response has come back,
   // then lets the core settle so that a late write cannot race a register.
   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_valid || owed_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes all four registers on consecutive cycles while the core is idle.
   task automatic program_core(logic [3:0] ln, logic [61:0] q, logic mode,
                               logic [63:0] qinv);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= CSR_LOG_N;
      csr_data <= {60'd0, ln};
      @(negedge clock);
      csr_index <= CSR_MODULUS;
      csr_data <= {2'b00, q};
      @(negedge clock);
      csr_index <= CSR_MODE;
      csr_data <= {63'd0, mode};
      @(negedge clock);
      csr_index <= CSR_QINV;
      csr_data <= qinv;
      @(negedge clock);
      csr_write_en <= 1'b0;
      model_log_n = ln;
      model_modulus = q;
      model_mode = mode;
      model_qinv = qinv;
   endtask

   function automatic logic [63:0] inverse_mod_2_64(logic [63:0] q);
      logic [63:0] x;
      x = q;
      repeat (6) x = x * (64'd2 - q * x);
      return x;
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   // Queues one request and records which entries it makes readable.
   task automatic queue_request(logic [2:0] kind, logic [11:0] slot, logic [63:0] word);
      req_type r;
      r.kind = kind;
      r.slot = slot;
      r.word = word;
      case (kind)
         KIND_WR_COEF: coef_loaded[slot] = 1'b1;
         KIND_WR_TWID: twid_loaded[slot] = 1'b1;
         KIND_WR_HINT: hint_loaded[slot] = 1'b1;
         default: ;
      endcase
      pending_requests.push_back(r);
   endtask

   // A coefficient value: fully reduced most of the time, raw 64 bits otherwise.
   function automatic logic [63:0] operand(logic [61:0] q);
      logic [63:0] w;
      w = random_word();
      if ($urandom_range(0, 3) != 0)
         w = w % {2'b00, q};
      return w;
   endfunction

   // One phase: program the core, load a full data set if runs are allowed, then random traffic.
   task automatic run_phase(logic [3:0] ln, logic [61:0] q, logic mode, logic [63:0] qinv,
                            int count, bit allow_run);
      int n;
      int pick;
      int run_odds;
      logic [11:0] slot;
      wait_idle();
      program_core(ln, q, mode, qinv);
      n = (ln > 12) ? POINTS : (1 << ln);
      if (allow_run) begin
         for (int i = 0; i < n; i++) begin
            queue_request(KIND_WR_COEF, i[11:0], operand(q));
            if (i != 0) begin
               queue_request(KIND_WR_TWID, i[11:0], operand(q));
               queue_request(KIND_WR_HINT, i[11:0], random_word());
            end
         end
      end
      run_odds = (n <= 16) ? 10 : 3;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         slot = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, n - 1)) :
                                              12'($urandom_range(0, 4095));
         if (pick < 35) begin
            queue_request(KIND_WR_COEF, slot, operand(q));
         end else if (pick < 45) begin
            queue_request(KIND_WR_TWID, slot, operand(q));
         end else if (pick < 55) begin
            queue_request(KIND_WR_HINT, slot, random_word());
         end else if (pick < 55 + run_odds) begin
            if (allow_run)
               queue_request(KIND_RUN, slot, random_word());
         end else if (pick < 95) begin
            if (!coef_loaded[slot])
               slot = $urandom_range(0, 1) ? 12'd0 : 12'(slot % n);
            if (coef_loaded[slot])
               queue_request(KIND_RD_COEF, slot, random_word());
         end else begin
            queue_request(3'($urandom_range(5, 7)), slot, random_word());
         end
      end
   endtask

   initial begin
      logic [61:0] q;
      logic [61:0] q_top;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_LOG_N;
      csr_data = '0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      mismatches = 0;
      idle_cycles = 0;
      model_log_n = 4'd12;
      model_modulus = 62'd3;
      model_mode = 1'b0;
      model_qinv = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: a one-point transform touches no memory, so it can run
      // before anything is loaded. Slot and word extremes, unknown kinds.
      program_core(4'd0, 62'd3, 1'b0, 64'd0);
      queue_request(KIND_WR_COEF, 12'd0, '1);
      queue_request(KIND_WR_COEF, 12'd4095, '0);
      queue_request(KIND_RD_COEF, 12'd0, '0);
      queue_request(KIND_RD_COEF, 12'd4095, '1);
      queue_request(KIND_WR_COEF, 12'd4095, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_request(KIND_RD_COEF, 12'd4095, '0);
      queue_request(KIND_WR_TWID, 12'd4095, '1);
      queue_request(KIND_WR_HINT, 12'd0, '1);
      queue_request(3'd5, 12'd0, '0);
      queue_request(3'd6, 12'd4095, '1);
      queue_request(3'd7, 12'd1, '0);
      queue_request(KIND_RUN, 12'd4095, '1);
      queue_request(KIND_RD_COEF, 12'd0, '0);

      // Random phases across lengths, both reduction modes and modulus extremes.
      q_top = {62{1'b1}};
      run_phase(4'd1, 62'd3, 1'b0, 64'd0, 60, 1'b1);
      run_phase(4'd2, 62'd3, 1'b1, inverse_mod_2_64(64'd3), 60, 1'b1);
      run_phase(4'd3, q_top, 1'b0, 64'd0, 120, 1'b1);
      run_phase(4'd4, q_top, 1'b1, inverse_mod_2_64({2'b00, q_top}), 120, 1'b1);
      for (int p = 0; p < 6; p++) begin
         q = 62'({$urandom(), $urandom()}) | 62'd1;
         if (q < 62'd3)
            q = 62'd3;
         run_phase(4'($urandom_range(1, 6)), q, p[0], inverse_mod_2_64({2'b00, q}), 80,
                   1'b1);
      end
      q = 62'({$urandom(), $urandom()}) | 62'd1;
      run_phase(4'd7, q, 1'b0, 64'd0, 100, 1'b1);
      // A modulus inverse that does not match the modulus is used as written.
      run_phase(4'd3, q, 1'b1, random_word(), 80, 1'b1);
      run_phase(4'd12, q, 1'b0, 64'd0, 80, 1'b0);

      wait_idle();
      if (mismatches == 0 && owed_responses.size() == 0)
         $display("** forward_ntt_modular_core: PASSED **");
      else
         $display("** forward_ntt_modular_core: FAILED **");
      $finish;
   end

endmodule
`default_nettype wire
